/* hdl/dtr_pkg.sv */
// ----------------------------------------------------------------------------
// Drift time to radius: shared definitions
// Widths, segment codes, curve coefficients and precomputed segment end values.
// ----------------------------------------------------------------------------
package dtr_pkg;

    localparam int T_W        = 24;
    localparam int RAD_W      = 20;
    localparam int SEG_W      = 3;
    localparam int ACC_W      = 46;
    localparam int FRAC_SHIFT = 17;
    localparam int PROD_W     = ACC_W + FRAC_SHIFT + 1;
    localparam int N_STEPS    = 9;

    // edges from the accepting edge to the edge that takes the result
    localparam int DTR_LATENCY = 24;

    typedef enum logic [SEG_W-1:0] {
        SEG_RAMP  = 3'd0,
        SEG_POLY  = 3'd1,
        SEG_LINE1 = 3'd2,
        SEG_LINE2 = 3'd3,
        SEG_HOLD  = 3'd4
    } t_segment;

    typedef struct packed {
        logic                    valid;
        logic signed [T_W-1:0]   t;
        logic signed [ACC_W-1:0] acc;
    } t_horner_bus;

    // curve coefficient j scaled by 2^(30-3j), in 2^-30 mm
    localparam longint C_COEF [0:N_STEPS] = '{
        64'sd1510690322,
        -64'sd38745034195,
        64'sd375346587238,
        -64'sd1519908814848,
        64'sd3636959641600,
        -64'sd5562236928000,
        64'sd5507727360000,
        -64'sd3421532160000,
        64'sd1212569600000,
        -64'sd187004800000
    };

    // curve value at a time of num/25 of the polynomial unit, truncating steps
    function automatic longint f_poly_frac(input longint num);
        longint acc;
        acc = C_COEF[N_STEPS];
        for (int k = N_STEPS - 1; k >= 0; k--) begin
            acc = (acc * num) / 64'sd25 + C_COEF[k];
        end
        return acc;
    endfunction

    localparam longint V_AT02   = f_poly_frac(64'sd4);
    localparam longint V_AT09   = f_poly_frac(64'sd18);
    localparam longint V_426    = 64'sd4574140170;
    localparam longint V_482767 = 64'sd5183671191;
    localparam longint V_OFFSET = 64'sd18253611;
    localparam longint V_ROUND  = 64'sd8192 - V_OFFSET;

    localparam logic signed [RAD_W-1:0] RADIUS_FLOOR = RAD_W'(V_ROUND >>> 14);
    localparam logic signed [RAD_W-1:0] RADIUS_HOLD  = RAD_W'((V_482767 + V_ROUND) >>> 14);

endpackage

/* hdl/dtr_horner_step.sv */
// ----------------------------------------------------------------------------
// Drift time to radius: Horner step
// One polynomial step in two stages: multiply by the low 17 bits of the time,
// then truncate toward zero by 2^17 and add the coefficient.
// ----------------------------------------------------------------------------
module dtr_horner_step
    import dtr_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic signed [ACC_W-1:0] i_coef,
    input  t_horner_bus             i_bus,
    output t_horner_bus             o_bus
);

    localparam logic [PROD_W-1:0] TRUNC_BIAS = PROD_W'((64'sd1 <<< FRAC_SHIFT) - 64'sd1);

    logic                      r_valid_a;
    logic signed [T_W-1:0]     r_t_a;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [PROD_W-1:0]  n_prod;
    logic signed [FRAC_SHIFT:0] w_tfrac;
    logic signed [PROD_W-1:0]  w_biased;
    logic                      r_valid_b;
    logic signed [T_W-1:0]     r_t_b;
    logic signed [ACC_W-1:0]   r_acc_b;
    logic signed [ACC_W-1:0]   n_acc;

    assign w_tfrac = $signed({1'b0, i_bus.t[FRAC_SHIFT-1:0]});
    assign n_prod  = i_bus.acc * w_tfrac;

    always_comb begin
        w_biased = r_prod + (r_prod[PROD_W-1] ? TRUNC_BIAS : '0);
        n_acc    = $signed(w_biased[FRAC_SHIFT +: ACC_W]) + i_coef;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_a <= 1'b0;
            r_valid_b <= 1'b0;
        end else begin
            r_valid_a <= i_bus.valid;
            r_valid_b <= r_valid_a;
        end
    end

    always_ff @(posedge i_clk) begin
        r_t_a   <= i_bus.t;
        r_prod  <= n_prod;
        r_t_b   <= r_t_a;
        r_acc_b <= n_acc;
    end

    assign o_bus = '{valid: r_valid_b, t: r_t_b, acc: r_acc_b};

endmodule

/* hdl/dtr_line_unit.sv */
// ----------------------------------------------------------------------------
// Drift time to radius: segment select and line interpolation
// Picks the segment, interpolates the ramp and the two lines by a constant
// gain and a reciprocal divide, applies the offset and rounds to 2^-16 mm.
// ----------------------------------------------------------------------------
module dtr_line_unit
    import dtr_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_horner_bus             i_bus,
    output logic                    o_strobe,
    output logic signed [RAD_W-1:0] o_radius,
    output logic [SEG_W-1:0]        o_segment
);

    localparam int W32         = 32;
    localparam int M_W         = 20;
    localparam int K_W         = 33;
    localparam int P_W         = K_W + M_W;
    localparam int A_W         = 34;
    localparam int R_W         = 33;
    localparam int Q_W         = A_W + R_W;
    localparam int RECIP_SHIFT = 35;
    localparam int QE_W        = Q_W - RECIP_SHIFT;
    localparam int REM_W       = 6;
    localparam int D_W         = 4;
    localparam int SUM_W       = ACC_W + 1;
    localparam int RAD_LSB     = 14;
    localparam int SHIFT_RAMP  = 16;
    localparam int SHIFT_LINE  = 17;

    localparam logic signed [T_W-1:0] T_RAMP_END  = T_W'(20971);
    localparam logic signed [T_W-1:0] T_POLY_END  = T_W'(94371);
    localparam logic signed [T_W-1:0] T_LINE1_END = T_W'(120586);
    localparam logic signed [T_W-1:0] T_LINE2_END = T_W'(157286);

    localparam logic signed [W32-1:0] RAMP_SLOPE   = 32'sd125;
    localparam logic signed [W32-1:0] LINE_SLOPE   = 32'sd25;
    localparam logic signed [W32-1:0] M_RAMP_OFS   = 32'sd2031616;
    localparam logic signed [W32-1:0] M_LINE1_OFS  = 32'sd2359296;
    localparam logic signed [W32-1:0] M_LINE2_OFS  = 32'sd3014656;

    localparam longint DIV_RAMP  = 64'sd9;
    localparam longint DIV_LINE1 = 64'sd5;
    localparam longint DIV_LINE2 = 64'sd7;

    localparam logic [K_W-1:0] K_RAMP  = K_W'(V_AT02);
    localparam logic [K_W-1:0] K_LINE1 = K_W'(V_426 - V_AT09);
    localparam logic [K_W-1:0] K_LINE2 = K_W'(V_482767 - V_426);

    localparam logic [R_W-1:0] R_RAMP  = R_W'((64'sd1 <<< RECIP_SHIFT) / DIV_RAMP);
    localparam logic [R_W-1:0] R_LINE1 = R_W'((64'sd1 <<< RECIP_SHIFT) / DIV_LINE1);
    localparam logic [R_W-1:0] R_LINE2 = R_W'((64'sd1 <<< RECIP_SHIFT) / DIV_LINE2);

    localparam logic signed [SUM_W-1:0] B_LINE1 = SUM_W'(V_AT09);
    localparam logic signed [SUM_W-1:0] B_LINE2 = SUM_W'(V_426);
    localparam logic signed [SUM_W-1:0] B_HOLD  = SUM_W'(V_482767);
    localparam logic signed [SUM_W-1:0] B_ROUND = SUM_W'(V_ROUND);

    function automatic logic [D_W-1:0] f_divisor(input t_segment seg);
        case (seg)
            SEG_RAMP:  return D_W'(DIV_RAMP);
            SEG_LINE1: return D_W'(DIV_LINE1);
            SEG_LINE2: return D_W'(DIV_LINE2);
            default:   return D_W'(1);
        endcase
    endfunction

    function automatic logic [K_W-1:0] f_gain(input t_segment seg);
        case (seg)
            SEG_RAMP:  return K_RAMP;
            SEG_LINE1: return K_LINE1;
            SEG_LINE2: return K_LINE2;
            default:   return '0;
        endcase
    endfunction

    function automatic logic [R_W-1:0] f_recip(input t_segment seg);
        case (seg)
            SEG_RAMP:  return R_RAMP;
            SEG_LINE1: return R_LINE1;
            SEG_LINE2: return R_LINE2;
            default:   return '0;
        endcase
    endfunction

    // stage 1: classify
    logic signed [W32-1:0]   w_t32;
    logic signed [W32-1:0]   w_m_ramp;
    logic signed [W32-1:0]   w_m_line1;
    logic signed [W32-1:0]   w_m_line2;
    t_segment                n_seg1;
    logic [M_W-1:0]          n_m1;
    logic                    r_valid1;
    t_segment                r_seg1;
    logic [M_W-1:0]          r_m1;
    logic signed [ACC_W-1:0] r_acc1;

    // stage 2: gain product
    logic [P_W-1:0]          n_prod2;
    logic                    r_valid2;
    t_segment                r_seg2;
    logic [P_W-1:0]          r_prod2;
    logic signed [ACC_W-1:0] r_acc2;

    // stage 3: reciprocal product
    logic [A_W-1:0]          w_a;
    logic [Q_W-1:0]          n_q3;
    logic                    r_valid3;
    t_segment                r_seg3;
    logic [A_W-1:0]          r_a3;
    logic [Q_W-1:0]          r_q3;
    logic signed [ACC_W-1:0] r_acc3;

    // stage 4: quotient estimate and remainder
    logic [QE_W-1:0]         w_qest;
    logic [REM_W-1:0]        n_rem4;
    logic                    r_valid4;
    t_segment                r_seg4;
    logic [QE_W-1:0]         r_qest4;
    logic [REM_W-1:0]        r_rem4;
    logic signed [ACC_W-1:0] r_acc4;

    // stage 5: sum and round
    logic [QE_W:0]           w_q;
    logic signed [SUM_W-1:0] w_base;
    logic signed [SUM_W-1:0] w_sum;
    logic                    r_strobe;
    logic signed [RAD_W-1:0] r_radius;
    logic [SEG_W-1:0]        r_segment;

    always_comb begin
        w_t32     = W32'(i_bus.t);
        w_m_ramp  = RAMP_SLOPE * w_t32 - M_RAMP_OFS;
        w_m_line1 = LINE_SLOPE * w_t32 - M_LINE1_OFS;
        w_m_line2 = LINE_SLOPE * w_t32 - M_LINE2_OFS;
        if (i_bus.t <= T_RAMP_END) begin
            n_seg1 = SEG_RAMP;
        end else if (i_bus.t <= T_POLY_END) begin
            n_seg1 = SEG_POLY;
        end else if (i_bus.t <= T_LINE1_END) begin
            n_seg1 = SEG_LINE1;
        end else if (i_bus.t <= T_LINE2_END) begin
            n_seg1 = SEG_LINE2;
        end else begin
            n_seg1 = SEG_HOLD;
        end
        case (n_seg1)
            SEG_RAMP:  n_m1 = (w_m_ramp > 0) ? w_m_ramp[M_W-1:0] : '0;
            SEG_LINE1: n_m1 = w_m_line1[M_W-1:0];
            SEG_LINE2: n_m1 = w_m_line2[M_W-1:0];
            default:   n_m1 = '0;
        endcase
    end

    assign n_prod2 = f_gain(r_seg1) * r_m1;

    always_comb begin
        if (r_seg2 == SEG_RAMP) begin
            w_a = A_W'(r_prod2 >> SHIFT_RAMP);
        end else begin
            w_a = A_W'(r_prod2 >> SHIFT_LINE);
        end
        n_q3 = w_a * f_recip(r_seg2);
    end

    always_comb begin
        w_qest = r_q3[RECIP_SHIFT +: QE_W];
        n_rem4 = r_a3[REM_W-1:0] - REM_W'(f_divisor(r_seg3) * w_qest[REM_W-1:0]);
    end

    always_comb begin
        w_q = {1'b0, r_qest4} + (QE_W+1)'(r_rem4 >= REM_W'(f_divisor(r_seg4)));
        case (r_seg4)
            SEG_POLY:  w_base = SUM_W'(r_acc4);
            SEG_LINE1: w_base = B_LINE1;
            SEG_LINE2: w_base = B_LINE2;
            SEG_HOLD:  w_base = B_HOLD;
            default:   w_base = '0;
        endcase
        w_sum = w_base + SUM_W'(w_q) + B_ROUND;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid1 <= 1'b0;
            r_valid2 <= 1'b0;
            r_valid3 <= 1'b0;
            r_valid4 <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_valid1 <= i_bus.valid;
            r_valid2 <= r_valid1;
            r_valid3 <= r_valid2;
            r_valid4 <= r_valid3;
            r_strobe <= r_valid4;
        end
    end

    always_ff @(posedge i_clk) begin
        r_seg1    <= n_seg1;
        r_m1      <= n_m1;
        r_acc1    <= i_bus.acc;
        r_seg2    <= r_seg1;
        r_prod2   <= n_prod2;
        r_acc2    <= r_acc1;
        r_seg3    <= r_seg2;
        r_a3      <= w_a;
        r_q3      <= n_q3;
        r_acc3    <= r_acc2;
        r_seg4    <= r_seg3;
        r_qest4   <= w_qest;
        r_rem4    <= n_rem4;
        r_acc4    <= r_acc3;
        r_radius  <= w_sum[RAD_LSB +: RAD_W];
        r_segment <= r_seg4;
    end

    assign o_strobe  = r_strobe;
    assign o_radius  = r_radius;
    assign o_segment = r_segment;

endmodule

/* hdl/drift_time_to_radius_top.sv */
// ----------------------------------------------------------------------------
// Drift time to radius
// Throughput: one request per cycle; busy is held low and results cannot stall.
// The result strobe is registered through one input stage, then nine Horner
// steps of two stages each (multiply, truncate-add), then five stages of
// segment select, interpolation and rounding.
// Reset: synchronous, active low; clears valid bits and drops requests in flight.
// ----------------------------------------------------------------------------
module drift_time_to_radius_top
    import dtr_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic signed [T_W-1:0]   i_drift_time,
    output logic                    o_strobe,
    output logic signed [RAD_W-1:0] o_radius,
    output logic [SEG_W-1:0]        o_segment
);

    logic                  r_s0_valid;
    logic signed [T_W-1:0] r_s0_t;
    t_horner_bus           w_bus [0:N_STEPS];

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else begin
            r_s0_valid <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s0_t <= i_drift_time;
    end

    assign w_bus[0] = '{valid: r_s0_valid, t: r_s0_t, acc: ACC_W'(C_COEF[N_STEPS])};

    for (genvar g = 0; g < N_STEPS; g++) begin : g_step
        dtr_horner_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_coef  (ACC_W'(C_COEF[N_STEPS-1-g])),
            .i_bus   (w_bus[g]),
            .o_bus   (w_bus[g+1])
        );
    end

    dtr_line_unit u_line (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_bus     (w_bus[N_STEPS]),
        .o_strobe  (o_strobe),
        .o_radius  (o_radius),
        .o_segment (o_segment)
    );

endmodule

/* hdl/dtr_checker.sv */
// ----------------------------------------------------------------------------
// Drift time to radius: port checker
// Checks request to result timing and the fixed ends of the curve.
// ----------------------------------------------------------------------------
module dtr_checker
    import dtr_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    input  logic                    busy,
    input  logic signed [T_W-1:0]   i_drift_time,
    input  logic                    o_strobe,
    input  logic signed [RAD_W-1:0] o_radius,
    input  logic [SEG_W-1:0]        o_segment
);

    a_request_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##DTR_LATENCY o_strobe)
        else $error("request without result");

    a_result_has_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start && !busy, DTR_LATENCY))
        else $error("result without request");

    a_hold_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_segment == SEG_HOLD) |-> (o_radius == RADIUS_HOLD))
        else $error("held segment radius wrong");

    a_negative_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && $past(i_drift_time[T_W-1], DTR_LATENCY))
        |-> (o_segment == SEG_RAMP && o_radius == RADIUS_FLOOR))
        else $error("negative time not clamped");

endmodule

bind drift_time_to_radius_top dtr_checker u_checker (.*);
